/* src/btba_pkg.sv */
package btba_pkg;

    // Image limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;                     // width of dimension registers and row count
    localparam int COL_W      = $clog2(MAX_WIDTH);      // column index into the line memory
    localparam int GAIN_W     = 9;
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [DIM_W-1:0]  MIN_DIM       = DIM_W'(3);
    localparam logic [DIM_W-1:0]  MAX_WIDTH_D   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  MAX_HEIGHT_D  = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0]  RESET_WIDTH   = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RESET_HEIGHT  = DIM_W'(480);
    localparam logic [GAIN_W-1:0] RESET_GAIN    = GAIN_W'(128);

    // Threshold: 256*(R+G+B) + 100*gain >= 38400
    localparam int THRESH_W = 19;
    localparam logic [THRESH_W-1:0] THRESH_LIMIT = THRESH_W'(38400);
    localparam logic [6:0]          GAIN_WEIGHT  = 7'd100;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_GAIN   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel_in;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_of_frame;
    } out_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    // One classified pixel with its four neighbours
    typedef struct packed {
        logic [PIX_W-1:0]   center;
        logic [COLOR_W-1:0] up;
        logic [COLOR_W-1:0] left;
        logic [COLOR_W-1:0] down;
        logic [COLOR_W-1:0] right;
        logic               interior;
        logic               last;
    } fe_item_t;

endpackage

/* src/bloom_threshold_blur_add.sv */
// Bloom filter on a raster ARGB stream: each pixel whose R+G+B reaches
// 150 - 100*gain/256 and that is not on the image border gets the mean of its
// four neighbours, scaled by gain/256, added to each color channel with
// saturation at 255; alpha passes through. A pixel comes out once the pixel
// below it has been pushed, so results trail the input by one row; the first
// row of a frame gives no result, and after the last row push drain items
// (cmd = 1), one per column, to flush it (a drain at any other time is taken
// and dropped). A pixel pushed while a last row waits flushes that row's pixel
// in the same column and starts the next frame. Sustained rate is one pixel
// per clock while full is low, set by the single line memory (1024 x 64
// bits, one write and one read port) that is written and prefetched once
// per transfer. A four-entry queue between the classifying front and the
// mixing back lets either side stall. The line memory has no clearing pass:
// contents are undefined until the first rows of a frame are in. Write width,
// height and gain only while the block is idle.
module bloom_threshold_blur_add (
    input  logic                                clk,
    input  logic                                rst_n,
    // input queue side
    input  logic                                push,
    output logic                                full,
    input  btba_pkg::in_t                       item,
    // result queue side
    output logic                                empty,
    input  logic                                pop,
    output btba_pkg::out_t                      result,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btba_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import btba_pkg::*;

    cfg_t                   cfg_reg;
    logic                   fe_push;
    fe_item_t               fe_item;
    fe_item_t               q_item;
    logic                   q_valid;
    logic                   q_pop;
    logic [FIFO_LVL_W-1:0]  q_level;

    // Writes are always taken; unused index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= RESET_WIDTH;
            cfg_reg.height <= RESET_HEIGHT;
            cfg_reg.gain   <= RESET_GAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_reg.width  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: cfg_reg.height <= cfg_data[DIM_W-1:0];
                CFG_GAIN:   cfg_reg.gain   <= cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Front: position tracking, line memory, neighbour gathering
    btba_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .item       (item),
        .full       (full),
        .fifo_level (q_level),
        .fe_push    (fe_push),
        .fe_item    (fe_item)
    );

    // Decoupling queue; the front never pushes without room
    btba_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_item (fe_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .nonempty  (q_valid),
        .level     (q_level)
    );

    // Back: threshold, blur, gain and saturating mix into the output register
    btba_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

/* src/btba_fifo.sv */
module btba_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  btba_pkg::fe_item_t                  push_item,
    input  logic                                pop,
    output btba_pkg::fe_item_t                  pop_item,
    output logic                                nonempty,
    output logic [btba_pkg::FIFO_LVL_W-1:0]     level
);
    import btba_pkg::*;

    fe_item_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_next;
    logic [FIFO_LVL_W-1:0]  count_reg;
    logic [FIFO_LVL_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = entry_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign level    = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FIFO_LVL_W'(FIFO_DEPTH)) || pop)
        else $error("fifo push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("fifo pop while empty");

endmodule

/* src/btba_front.sv */
module btba_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  btba_pkg::cfg_t                      cfg,
    input  logic                                push,
    input  btba_pkg::in_t                       item,
    output logic                                full,
    input  logic [btba_pkg::FIFO_LVL_W-1:0]     fifo_level,
    output logic                                fe_push,
    output btba_pkg::fe_item_t                  fe_item
);
    import btba_pkg::*;

    logic [DIM_W-1:0]     w;
    logic [DIM_W-1:0]     h;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [DIM_W-1:0]     row_reg;
    logic [DIM_W-1:0]     row_next;
    logic [DIM_W-1:0]     col_wide;
    logic [DIM_W-1:0]     col_eff_wide;
    logic [COL_W-1:0]     col_eff;
    logic [DIM_W-1:0]     row_eff;
    logic [DIM_W-1:0]     r;
    logic                 drain;
    logic                 ignore;
    logic                 take;
    logic                 emit;
    logic                 wrap;
    logic                 interior;
    logic                 last;
    logic [FIFO_LVL_W-1:0] in_flight;

    // Line memory: one word per column, {older row, newer row}
    logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]   entry_reg;        // prefetched entry of the current column
    logic [PIX_W-1:0]     prev_newer_reg;   // newer row, previous column

    logic                 s1_valid_reg;
    logic [PIX_W-1:0]     s1_center_reg;
    logic [COLOR_W-1:0]   s1_up_reg;
    logic [COLOR_W-1:0]   s1_left_reg;
    logic [COLOR_W-1:0]   s1_down_reg;
    logic                 s1_interior_reg;
    logic                 s1_last_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < MIN_DIM)
        begin
            res = MIN_DIM;
        end
        else if (v > hi)
        begin
            res = hi;
        end
        return res;
    endfunction

    always_comb
    begin
        w            = clamp_dim(cfg.width, MAX_WIDTH_D);
        h            = clamp_dim(cfg.height, MAX_HEIGHT_D);
        col_wide     = DIM_W'(col_reg);
        col_eff_wide = (col_wide >= w) ? w - 1'b1 : col_wide;
        col_eff      = col_eff_wide[COL_W-1:0];
        row_eff      = (row_reg > h) ? h : row_reg;
        drain        = item.cmd;
        ignore       = drain && (row_eff != h);
        // the prefetch stage plus the queue must have room for one more
        in_flight    = fifo_level + FIFO_LVL_W'(s1_valid_reg);
        full         = (in_flight >= FIFO_LVL_W'(FIFO_DEPTH));
        take         = push && !full && !ignore;
        emit         = (row_eff != '0);
        r            = row_eff - 1'b1;
        interior     = (r >= DIM_W'(1)) && (r <= h - DIM_W'(2))
                    && (col_eff_wide >= DIM_W'(1)) && (col_eff_wide <= w - DIM_W'(2));
        last         = (r == h - 1'b1) && (col_eff_wide == w - 1'b1);
        wrap         = (col_eff_wide == w - 1'b1);
        col_next     = wrap ? '0 : col_eff + 1'b1;
        row_next     = row_eff;
        if (wrap)
        begin
            if (row_eff == h)
            begin
                row_next = drain ? '0 : DIM_W'(1);
            end
            else
            begin
                row_next = row_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take && emit;
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Write the current column, prefetch the next one
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            line_mem[col_eff] <= {entry_reg[PIX_W-1:0],
                                  drain ? entry_reg[PIX_W-1:0] : item.pixel_in};
            entry_reg         <= line_mem[col_next];
            prev_newer_reg    <= entry_reg[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_center_reg   <= entry_reg[PIX_W-1:0];
            s1_up_reg       <= entry_reg[PIX_W+COLOR_W-1:PIX_W];
            s1_left_reg     <= prev_newer_reg[COLOR_W-1:0];
            s1_down_reg     <= item.pixel_in[COLOR_W-1:0];
            s1_interior_reg <= interior;
            s1_last_reg     <= last;
        end
    end

    // right neighbour arrives with the prefetch, registered on the transfer like the other fields
    always_comb
    begin
        fe_item.center   = s1_center_reg;
        fe_item.up       = s1_up_reg;
        fe_item.left     = s1_left_reg;
        fe_item.down     = s1_down_reg;
        fe_item.right    = entry_reg[COLOR_W-1:0];
        fe_item.interior = s1_interior_reg;
        fe_item.last     = s1_last_reg;
    end

    assign fe_push = s1_valid_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> DIM_W'(col_reg) < w)
        else $error("column count past row width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> row_reg <= h)
        else $error("row count past frame height");

endmodule

/* src/btba_back.sv */
module btba_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  btba_pkg::cfg_t          cfg,
    input  logic                    item_valid,
    input  btba_pkg::fe_item_t      item,
    output logic                    item_pop,
    output btba_pkg::out_t          result,
    output logic                    empty,
    input  logic                    pop
);
    import btba_pkg::*;

    localparam int PROD_W = CHAN_W + GAIN_W;

    logic                   b1_valid_reg;
    logic [PIX_W-1:0]       b1_center_reg;
    logic [COLOR_W-1:0]     b1_blur_reg;
    logic                   b1_last_reg;

    logic                   b2_valid_reg;
    logic [PIX_W-1:0]       b2_center_reg;
    logic [PROD_W-1:0]      b2_prod_reg [3];
    logic                   b2_last_reg;

    logic                   b3_valid_reg;
    out_t                   b3_reg;

    logic                   b1_ready;
    logic                   b2_ready;
    logic                   b3_ready;
    logic                   hot;
    logic [COLOR_W-1:0]     blur;
    logic [THRESH_W-1:0]    weight;
    out_t                   mixed;

    function automatic logic [CHAN_W-1:0] chan(input logic [COLOR_W-1:0] px, input int k);
        return px[k*CHAN_W +: CHAN_W];
    endfunction

    always_comb
    begin
        b3_ready = !b3_valid_reg || pop;
        b2_ready = !b2_valid_reg || b3_ready;
        b1_ready = !b1_valid_reg || b2_ready;
        item_pop = item_valid && b1_ready;
    end

    // Threshold and four-neighbour mean
    always_comb
    begin
        weight = THRESH_W'({2'b00, chan(item.center[COLOR_W-1:0], 0)}
                         + {2'b00, chan(item.center[COLOR_W-1:0], 1)}
                         + {2'b00, chan(item.center[COLOR_W-1:0], 2)}) << CHAN_W;
        weight = weight + THRESH_W'(cfg.gain * GAIN_WEIGHT);
        hot    = item.interior && (weight >= THRESH_LIMIT);
        for (int k = 0; k < 3; k++)
        begin
            logic [CHAN_W+1:0] s;
            s = {2'b00, chan(item.up, k)} + {2'b00, chan(item.down, k)}
              + {2'b00, chan(item.left, k)} + {2'b00, chan(item.right, k)};
            blur[k*CHAN_W +: CHAN_W] = hot ? s[CHAN_W+1:2] : '0;
        end
    end

    // Additive mix with saturation
    always_comb
    begin
        mixed.pixel_out     = '0;
        mixed.pixel_out[PIX_W-1:COLOR_W] = b2_center_reg[PIX_W-1:COLOR_W];
        mixed.last_of_frame = b2_last_reg;
        for (int k = 0; k < 3; k++)
        begin
            logic [CHAN_W+1:0] v;
            v = {2'b00, b2_center_reg[k*CHAN_W +: CHAN_W]}
              + {1'b0, b2_prod_reg[k][PROD_W-1:CHAN_W]};
            mixed.pixel_out[k*CHAN_W +: CHAN_W] = (v > (CHAN_W+2)'(255)) ? '1 : v[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_ready)
            begin
                b1_valid_reg <= item_valid;
            end
            if (b2_ready)
            begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (b3_ready)
            begin
                b3_valid_reg <= b2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            b1_center_reg <= item.center;
            b1_blur_reg   <= blur;
            b1_last_reg   <= item.last;
        end
        if (b2_ready && b1_valid_reg)
        begin
            b2_center_reg <= b1_center_reg;
            b2_last_reg   <= b1_last_reg;
            for (int k = 0; k < 3; k++)
            begin
                b2_prod_reg[k] <= b1_blur_reg[k*CHAN_W +: CHAN_W] * cfg.gain;
            end
        end
        if (b3_ready && b2_valid_reg)
        begin
            b3_reg <= mixed;
        end
    end

    assign result = b3_reg;
    assign empty  = !b3_valid_reg;

endmodule
